// File: rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Short-term plasticity synapse package
// Shared types, constants, the exponential table and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package stp_pkg;
  localparam int NUM_PRE     = 256;
  localparam int MAX_TARGETS = 64;
  localparam int SYN_COUNT   = NUM_PRE * MAX_TARGETS;
  localparam int ADDR_W      = $clog2(SYN_COUNT);
  localparam int PRE_W       = $clog2(NUM_PRE);
  localparam int SLOT_W      = $clog2(MAX_TARGETS);

  localparam logic [15:0] X_RESET = 16'd6554;
  localparam logic [15:0] Y_RESET = 16'd26214;

  localparam logic [1:0] REG_U  = 2'd0;
  localparam logic [1:0] REG_FD = 2'd1;
  localparam logic [1:0] REG_DR = 2'd2;

  typedef struct packed {
    logic [7:0]         pre_index;
    logic [5:0]         target_slot;
    logic [15:0]        steps_since_spike;
    logic signed [15:0] weight;
  } stp_in_t;

  typedef struct packed {
    logic [5:0]         target_out;
    logic signed [31:0] released_current;
    logic signed [31:0] running_total;
  } stp_out_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_BUSY} stp_state_t;

  function automatic logic [16:0] exp_entry(input logic [4:0] k);
    case (k)
      5'd0:  exp_entry = 17'd65535;
      5'd1:  exp_entry = 17'd65534;
      5'd2:  exp_entry = 17'd65532;
      5'd3:  exp_entry = 17'd65528;
      5'd4:  exp_entry = 17'd65520;
      5'd5:  exp_entry = 17'd65504;
      5'd6:  exp_entry = 17'd65472;
      5'd7:  exp_entry = 17'd65408;
      5'd8:  exp_entry = 17'd65280;
      5'd9:  exp_entry = 17'd65026;
      5'd10: exp_entry = 17'd64520;
      5'd11: exp_entry = 17'd63520;
      5'd12: exp_entry = 17'd61565;
      5'd13: exp_entry = 17'd57835;
      5'd14: exp_entry = 17'd51039;
      5'd15: exp_entry = 17'd39750;
      5'd16: exp_entry = 17'd24109;
      5'd17: exp_entry = 17'd8869;
      5'd18: exp_entry = 17'd1200;
      5'd19: exp_entry = 17'd22;
      default: exp_entry = 17'd65536;
    endcase
  endfunction

  // Rounded Q1.16 product of two values up to one.
  function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] p;
    p = 35'(a) * 35'(b) + 35'd32768;
    qmul = 17'(p >> 16);
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hFFFF : v[15:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/stp_exp_unit.sv
// ----------------------------------------------------------------------------
// Exponential unit
// Forms exp(-steps*rate) in Q1.16, one exponent bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stp_exp_unit import stp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] steps,
  input  wire logic [15:0] rate,
  output logic             done,
  output logic [16:0]      result
);
  logic [31:0] a;
  logic [4:0]  k;
  logic        busy;
  logic [16:0] acc;

  // An exponent at or above bit 20 zeroes the result, but the unit still
  // walks all 20 bits so that both units always finish together.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (k == 5'd19);
      if (start) begin
        a    <= 32'(steps) * 32'(rate);
        k    <= '0;
        acc  <= 17'd65536;
        busy <= 1'b1;
      end else if (busy) begin
        if (a[31:20] != '0) acc <= '0;
        else if (a[k]) acc <= qmul(acc, exp_entry(k));
        if (k == 5'd19) busy <= 1'b0;
        k <= k + 5'd1;
      end
    end
  end
  assign result = acc;
endmodule
`default_nettype wire

// File: rtl/short_term_plasticity_synapse_top.sv
// ----------------------------------------------------------------------------
// Short-term plasticity synapse top level
// Per-synapse resource and facilitation update with release current output.
// ----------------------------------------------------------------------------
// Usage: one input transaction (in_valid/in_ready, struct in_data) carries a
// synapse event; exactly one output transaction (out_valid/out_ready,
// out_data) follows with the released current and the running total.
// Registers are written through the APB-style port at byte addresses 0, 4, 8.
// After reset the block sweeps all SYN_COUNT entries of both state memories, one
// entry per cycle, before it raises in_ready; configuration writes work meanwhile.
// The stages of an event, in order: the exponential units (one exponent bit
// per cycle, both exponentials in parallel, the memory read overlapping them),
// five arithmetic steps of which the first takes the exponentials, the load
// of the output register, at which out_valid rises, and the return to the
// idle state, where in_ready is high again for the next event.
// Events are handled one at a time, so a memory entry is never read while a
// write to it is still pending. The output register holds a result while the
// receiver stalls; a new event is accepted while that result waits, but the
// next result is held back, with in_ready low, until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module short_term_plasticity_synapse_top import stp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire stp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output stp_out_t      out_data,
  input  wire logic     psel,
  input  wire logic     penable,
  input  wire logic     pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  logic [15:0] facilitation_u, facil_decay_rate, depress_recovery_rate;
  logic [1:0]  reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      facilitation_u <= '0;
      facil_decay_rate <= '0;
      depress_recovery_rate <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_U:  facilitation_u <= pwdata[15:0];
        REG_FD: facil_decay_rate <= pwdata[15:0];
        REG_DR: depress_recovery_rate <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_U:   prdata = {16'd0, facilitation_u};
      REG_FD:  prdata = {16'd0, facil_decay_rate};
      REG_DR:  prdata = {16'd0, depress_recovery_rate};
      default: prdata = '0;
    endcase
  end

  // State memories.
  logic [15:0] x_mem [SYN_COUNT];
  logic [15:0] y_mem [SYN_COUNT];
  logic [15:0] x_rd, y_rd;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [15:0] x_wr, y_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= x_wr;
      y_mem[wr_addr] <= y_wr;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  stp_state_t state, state_next;
  logic [ADDR_W:0] clr_cnt;
  logic [4:0]  step;
  stp_in_t     item;
  logic        in_range;
  logic [ADDR_W-1:0] idx;
  logic signed [31:0] total;
  logic        ef_done, ed_done, exp_start;
  logic [16:0] ef, ed;
  logic [16:0] x, y;
  logic signed [47:0] jx;
  logic signed [63:0] p;
  logic        res_ready;
  logic signed [31:0] rel;
  logic        load_out;

  assign in_range = 32'(item.pre_index) < NUM_PRE && 32'(item.target_slot) < MAX_TARGETS;
  assign idx = ADDR_W'(item.pre_index) * ADDR_W'(MAX_TARGETS) + ADDR_W'(item.target_slot);
  assign rd_addr = idx;

  // The exponential units start at the accepting edge, so they take the step
  // count straight from the input channel.
  stp_exp_unit u_ef (.clk, .rst, .start(exp_start), .steps(in_data.steps_since_spike),
    .rate(facil_decay_rate), .done(ef_done), .result(ef));
  stp_exp_unit u_ed (.clk, .rst, .start(exp_start), .steps(in_data.steps_since_spike),
    .rate(depress_recovery_rate), .done(ed_done), .result(ed));

  assign in_ready = (state == ST_IDLE);
  assign load_out = (state == ST_BUSY) && res_ready && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == (ADDR_W+1)'(SYN_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_BUSY;
      ST_BUSY:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  assign exp_start = (state == ST_IDLE) && in_valid;

  // Sequencer: clear sweep; per event step 0 waits for and applies the exponentials; 1..4 arithmetic.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      step <= '0;
      res_ready <= 1'b0;
      total <= '0;
      out_valid <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          wr_en <= 1'b1;
          wr_addr <= clr_cnt[ADDR_W-1:0];
          x_wr <= X_RESET;
          y_wr <= Y_RESET;
        end
        ST_IDLE: begin
          wr_en <= 1'b0;
          if (in_valid) begin
            item <= in_data;
            step <= '0;
            res_ready <= 1'b0;
          end
        end
        ST_BUSY: begin
          wr_en <= !res_ready && (step == 5'd4) && in_range;
          if (!res_ready) begin
            case (step)
              5'd0: if (ef_done && ed_done) begin
                x <= 17'd65536 - qmul(17'd65536 - 17'(x_rd), ed);
                y <= qmul(17'(y_rd), ef);
                step <= 5'd1;
              end
              5'd1: begin
                x <= 17'(sat16(x));
                y <= 17'(sat16(y + qmul(17'(facilitation_u), 17'd65536 - y)));
                step <= 5'd2;
              end
              5'd2: begin
                jx <= 48'(item.weight) * $signed({1'b0, x[15:0]});
                step <= 5'd3;
              end
              5'd3: begin
                p <= 64'(jx) * $signed({1'b0, y[15:0]});
                step <= 5'd4;
              end
              5'd4: begin
                logic signed [64:0] r;
                logic signed [32:0] t;
                r = (65'(p) + 65'sd32768) >>> 16;
                if (in_range) begin
                  rel <= 32'(r);
                  t = 33'(total) + 33'(r);
                  if (t > 33'sd2147483647) total <= 32'h7FFFFFFF;
                  else if (t < -33'sd2147483648) total <= 32'h80000000;
                  else total <= t[31:0];
                  wr_addr <= idx;
                  x_wr <= sat16(qmul(x, 17'd65536 - y));
                  y_wr <= y[15:0];
                end else begin
                  rel <= '0;
                end
                res_ready <= 1'b1;
              end
              default: step <= '0;
            endcase
          end else if (load_out) begin
            out_data.target_out <= item.target_slot;
            out_data.released_current <= rel;
            out_data.running_total <= total;
          end
        end
        default: wr_en <= 1'b0;
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("accept during clear");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_exp_pair: assert property (@(posedge clk) disable iff (rst)
    ef_done == ed_done) else $error("exp units out of step");
endmodule
`default_nettype wire
